/* hdl/randomized_block_hadamard_rotation_defines.svh */
// assertion macros shared by the rotation block modules
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef RANDOMIZED_BLOCK_HADAMARD_ROTATION_DEFINES_SVH
`define RANDOMIZED_BLOCK_HADAMARD_ROTATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RBH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBH_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBH_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBH_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* hdl/rbh_pkg.sv */
// shared types, constants and helpers of the block hadamard rotation
// used by every module of the block but rbh_ram; depends on nothing
`default_nettype none

package rbh_pkg;

    localparam int MAX_DIM_DEF    = 1024;
    localparam int ROUNDS_DEF     = 2;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_W    = 2;
    localparam int RND_W   = 3;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 32;
    localparam int SCALE_W = 18;
    localparam int LEN_W   = 11;
    localparam int GW      = 64;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET  = 11'd1024;
    localparam logic [31:0]      INV_SQRT2  = 32'd3037000500;
    localparam logic [0:0]       REG_VECTOR_LENGTH = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_TABLE = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SCALE, S_RD_OUT, S_ROT_START,
        S_G_PERM, S_G_SRC, S_G_WR,
        S_B_RDA, S_B_RDB, S_B_WRA, S_B_WRB,
        S_N_RD, S_N_MAG, S_N_LO, S_N_HI, S_N_WR
    } t_state;

    typedef struct packed {
        logic load;
        logic tbl_write;
        logic mul;
        logic vs_write;
        logic rd_item;
        logic out_load;
        logic rot_init;
        logic perm_rd;
        logic src_rd;
        logic g_wr;
        logic inc_i;
        logic clr_i;
        logic bf_init;
        logic g_rd_a;
        logic g_rd_b;
        logic lat_a;
        logic wr_sum;
        logic wr_diff;
        logic inc_q;
        logic next_stage;
        logic g_rd_n;
        logic n_mag;
        logic n_lo;
        logic n_hi;
        logic wb_wr;
        logic next_round;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic last;
        logic len_nonzero;
        logic i_last;
        logic q_last;
        logic s_last;
        logic r_last;
        logic k_zero;
        logic out_free;
    } t_status;

    // round to nearest, ties away from zero, on a magnitude
    function automatic logic [GW-1:0] round_shift(input logic [GW-1:0] x,
                                                  input logic [4:0] s);
        logic [GW-1:0] half;
        half = (s == 5'd0) ? '0 : (64'd1 << (s - 5'd1));
        round_shift = (s == 5'd0) ? x : ((x + half) >> s);
    endfunction

endpackage

`default_nettype wire

/* hdl/rbh_if.sv */
// item and result channels of the rotation block, valid/ready handshake
// depends on rbh_pkg for the field widths
`default_nettype none

interface rbh_item_if import rbh_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [RND_W-1:0]     round;
    logic [IDX_W-1:0]     index;
    logic [POS_W-1:0]     source_position;
    logic                 sign_negative;
    logic signed [VAL_W-1:0] value;
    logic [SCALE_W-1:0]   scale;
    logic                 last;

    modport source (output valid, operation, round, index, source_position,
                    sign_negative, value, scale, last, input ready);
    modport sink (input valid, operation, round, index, source_position,
                  sign_negative, value, scale, last, output ready);
endinterface

interface rbh_result_if import rbh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;

    modport source (output valid, out_index, out_value, input ready);
    modport sink (input valid, out_index, out_value, output ready);
endinterface

`default_nettype wire

/* hdl/rbh_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

/* hdl/rbh_ctrl.sv */
// sequencer of the rotation block: decodes items and steps the rounds
// depends on rbh_pkg and the assertion macros header
`default_nettype none
`include "randomized_block_hadamard_rotation_defines.svh"

module rbh_ctrl import rbh_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_st.op)
                    OP_TABLE: begin
                        o_cmd.tbl_write = 1'b1;
                        n_state         = S_IDLE;
                    end
                    OP_DATA: begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_SCALE;
                    end
                    OP_READ: begin
                        o_cmd.rd_item = 1'b1;
                        n_state       = S_RD_OUT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCALE: begin
                o_cmd.vs_write = 1'b1;
                n_state = (i_st.last && i_st.len_nonzero) ? S_ROT_START : S_IDLE;
            end
            S_RD_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ROT_START: begin
                o_cmd.rot_init = 1'b1;
                n_state        = S_G_PERM;
            end
            S_G_PERM: begin
                o_cmd.perm_rd = 1'b1;
                n_state       = S_G_SRC;
            end
            S_G_SRC: begin
                o_cmd.src_rd = 1'b1;
                n_state      = S_G_WR;
            end
            S_G_WR: begin
                o_cmd.g_wr = 1'b1;
                if (i_st.i_last) begin
                    o_cmd.clr_i = 1'b1;
                    if (i_st.k_zero) begin
                        n_state = S_N_RD;
                    end else begin
                        o_cmd.bf_init = 1'b1;
                        n_state       = S_B_RDA;
                    end
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_G_PERM;
                end
            end
            S_B_RDA: begin
                o_cmd.g_rd_a = 1'b1;
                n_state      = S_B_RDB;
            end
            S_B_RDB: begin
                o_cmd.g_rd_b = 1'b1;
                o_cmd.lat_a  = 1'b1;
                n_state      = S_B_WRA;
            end
            S_B_WRA: begin
                o_cmd.wr_sum = 1'b1;
                n_state      = S_B_WRB;
            end
            S_B_WRB: begin
                o_cmd.wr_diff = 1'b1;
                if (i_st.q_last) begin
                    if (i_st.s_last) begin
                        n_state = S_N_RD;
                    end else begin
                        o_cmd.next_stage = 1'b1;
                        n_state          = S_B_RDA;
                    end
                end else begin
                    o_cmd.inc_q = 1'b1;
                    n_state     = S_B_RDA;
                end
            end
            S_N_RD: begin
                o_cmd.g_rd_n = 1'b1;
                n_state      = S_N_MAG;
            end
            S_N_MAG: begin
                o_cmd.n_mag = 1'b1;
                n_state     = S_N_LO;
            end
            S_N_LO: begin
                o_cmd.n_lo = 1'b1;
                n_state    = S_N_HI;
            end
            S_N_HI: begin
                o_cmd.n_hi = 1'b1;
                n_state    = S_N_WR;
            end
            S_N_WR: begin
                o_cmd.wb_wr = 1'b1;
                if (i_st.i_last) begin
                    if (i_st.r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_round = 1'b1;
                        n_state          = S_G_PERM;
                    end
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_N_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `RBH_ASSERT(a_accept_decodes, i_clk, i_rst_n, w_accept |=> (r_state == S_DECODE), "accepted item not decoded")
    `RBH_NEVER(a_out_no_overrun, i_clk, i_rst_n, o_cmd.out_load && !i_st.out_free, "result register overrun")
endmodule

`default_nettype wire

/* hdl/rbh_datapath.sv */
// buffers, tables, butterfly and normalisation arithmetic of the rotation
// depends on rbh_pkg, rbh_ram and the assertion macros header
`default_nettype none
`include "randomized_block_hadamard_rotation_defines.svh"

module rbh_datapath import rbh_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ROUNDS     = ROUNDS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_status                  o_st,
    input  wire logic [LEN_W-1:0]    i_len,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [RND_W-1:0]    i_round,
    input  wire logic [IDX_W-1:0]    i_index,
    input  wire logic [POS_W-1:0]    i_source_position,
    input  wire logic                i_sign_negative,
    input  wire logic [VAL_W-1:0]    i_value,
    input  wire logic [SCALE_W-1:0]  i_scale,
    input  wire logic                i_last,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [IDX_W-1:0]         o_out_index,
    output logic [VAL_W-1:0]         o_out_value
);
    localparam int AW  = $clog2(MAX_DIM);
    localparam int LW  = $clog2(MAX_DIM + 1);
    localparam int KW  = $clog2(LW);
    localparam int TD  = ROUNDS * MAX_DIM;
    localparam int TW  = $clog2(TD);
    localparam int RCW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int VB  = VALUE_BITS;

    function automatic logic [GW-1:0] saturate(input logic neg, input logic [GW-1:0] mag,
                                               input int bits);
        logic [GW-1:0] lim;
        lim = (64'd1 << (bits - 1)) - 64'd1;
        if (!neg) begin
            saturate = (mag > lim) ? lim : mag;
        end else if (mag > lim + 64'd1) begin
            saturate = ~lim;
        end else begin
            saturate = 64'd0 - mag;
        end
    endfunction

    // captured item
    logic [OP_W-1:0]    r_op;
    logic [RND_W-1:0]   r_rnd;
    logic [IDX_W-1:0]   r_idx;
    logic [POS_W-1:0]   r_pos;
    logic               r_sgn;
    logic [VAL_W-1:0]   r_val;
    logic [SCALE_W-1:0] r_scale;
    logic               r_last;

    // sequencing counters
    logic [AW-1:0]  r_i, r_q;
    logic [KW-1:0]  r_s, r_k;
    logic [RCW-1:0] r_r;

    logic [LW-1:0]  len_eff, block;
    logic [KW-1:0]  k_calc;

    logic [49:0]    r_prod;
    logic           r_vneg;
    logic           r_rd_ok, r_p_ok, r_src_wb;
    logic [GW-1:0]  r_a, r_b, r_mag, r_lp, r_mid;
    logic           r_neg;

    // memory ports
    logic [TW-1:0]    perm_waddr, perm_raddr;
    logic [POS_W:0]   perm_rdata;
    logic             perm_we;
    logic             vs_we, wb_we, wb_re, g_we, g_re;
    logic [AW-1:0]    wb_raddr, g_waddr, g_raddr, src_addr;
    logic [VB-1:0]    vs_wdata, vs_rdata, wb_wdata, wb_rdata, src_data;
    logic [GW-1:0]    g_wdata, g_rdata, src_ext, wb_ext;
    logic [AW-1:0]    bf_h, bf_a, bf_b;

    logic [32:0]      in_mag33;
    logic [GW-1:0]    nres, vres;
    logic [GW-1:0]    wb_sat, rd_sat;
    logic [4:0]       n_e;

    assign len_eff = (int'(i_len) > MAX_DIM) ? LW'(MAX_DIM) : LW'(i_len);
    assign block   = len_eff & (~len_eff + LW'(1));

    always_comb begin
        k_calc = '0;
        for (int b = 0; b < LW; b++) begin
            if (block[b]) begin
                k_calc = KW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_rnd   <= i_round;
            r_idx   <= i_index;
            r_pos   <= i_source_position;
            r_sgn   <= i_sign_negative;
            r_val   <= i_value;
            r_scale <= i_scale;
            r_last  <= i_last;
        end
        if (i_cmd.rot_init) begin
            r_k <= k_calc;
            r_r <= '0;
        end else if (i_cmd.next_round) begin
            r_r <= r_r + RCW'(1);
        end
        if (i_cmd.rot_init || i_cmd.clr_i || i_cmd.next_round) begin
            r_i <= '0;
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + AW'(1);
        end
        if (i_cmd.bf_init || i_cmd.next_stage) begin
            r_q <= '0;
        end else if (i_cmd.inc_q) begin
            r_q <= r_q + AW'(1);
        end
        if (i_cmd.bf_init) begin
            r_s <= '0;
        end else if (i_cmd.next_stage) begin
            r_s <= r_s + KW'(1);
        end
    end

    assign o_st.op          = t_op'(r_op);
    assign o_st.last        = r_last;
    assign o_st.len_nonzero = (len_eff != '0);
    assign o_st.i_last      = (LW'(r_i) == len_eff - LW'(1));
    assign o_st.q_last      = (LW'(r_q) == (len_eff >> 1) - LW'(1));
    assign o_st.s_last      = (r_s == r_k - KW'(1));
    assign o_st.r_last      = (r_r == RCW'(ROUNDS - 1));
    assign o_st.k_zero      = (r_k == '0);
    assign o_st.out_free    = !o_out_valid || i_out_ready;

    // scaled input element
    assign in_mag33 = r_val[VAL_W-1] ? (33'h1_0000_0000 - {1'b0, r_val}) : {1'b0, r_val};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 50'(in_mag33[31:0]) * 50'(r_scale);
            r_vneg <= r_val[VAL_W-1];
        end
    end

    assign vres     = saturate(r_vneg, round_shift({14'b0, r_prod}, 5'd16), VB);
    assign vs_we    = i_cmd.vs_write && (int'(r_idx) < MAX_DIM);
    assign vs_wdata = vres[VB-1:0];

    // table write, both tables share one word
    assign perm_we    = i_cmd.tbl_write && (int'(r_rnd) < ROUNDS) && (int'(r_idx) < MAX_DIM);
    assign perm_waddr = TW'(TW'(r_rnd) * TW'(MAX_DIM) + TW'(r_idx));
    assign perm_raddr = TW'(TW'(r_r) * TW'(MAX_DIM) + TW'(r_i));

    // gather: permutation entry selects the source element
    assign src_addr = AW'(perm_rdata[POS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_rd) begin
            r_p_ok   <= int'(perm_rdata[POS_W-1:0]) < int'(len_eff);
            r_src_wb <= (r_r != '0);
        end
        if (i_cmd.rd_item) begin
            r_rd_ok <= int'(r_idx) < int'(len_eff);
        end
    end

    assign src_data = r_src_wb ? wb_rdata : vs_rdata;
    assign src_ext  = r_p_ok ? {{(GW-VB){src_data[VB-1]}}, src_data} : '0;

    // butterfly pair positions for stage s
    assign bf_h = AW'(1) << r_s;
    assign bf_a = r_q + (r_q & ~(bf_h - AW'(1)));
    assign bf_b = bf_a + bf_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_a <= g_rdata;
        end
        if (i_cmd.wr_sum) begin
            r_b <= g_rdata;
        end
    end

    always_comb begin
        g_we    = i_cmd.g_wr || i_cmd.wr_sum || i_cmd.wr_diff;
        g_waddr = r_i;
        g_wdata = perm_rdata[POS_W] ? (64'd0 - src_ext) : src_ext;
        if (i_cmd.wr_sum) begin
            g_waddr = bf_a;
            g_wdata = r_a + g_rdata;
        end else if (i_cmd.wr_diff) begin
            g_waddr = bf_b;
            g_wdata = r_a - r_b;
        end
        g_re    = i_cmd.g_rd_a || i_cmd.g_rd_b || i_cmd.g_rd_n;
        g_raddr = r_i;
        if (i_cmd.g_rd_a) begin
            g_raddr = bf_a;
        end else if (i_cmd.g_rd_b) begin
            g_raddr = bf_b;
        end
    end

    // normalisation by 2^(-k/2), odd k through the 1/sqrt(2) product
    always_ff @(posedge i_clk) begin
        if (i_cmd.n_mag) begin
            r_neg <= g_rdata[GW-1];
            r_mag <= g_rdata[GW-1] ? (64'd0 - g_rdata) : g_rdata;
        end
        if (i_cmd.n_lo) begin
            r_lp <= r_mag[31:0] * INV_SQRT2;
        end
        if (i_cmd.n_hi) begin
            r_mid <= r_mag[63:32] * INV_SQRT2 + {32'b0, r_lp[63:32]};
        end
    end

    assign n_e = 5'((r_k - KW'(1)) >> 1);

    always_comb begin
        if (r_k[0]) begin
            nres = (n_e == 5'd0) ? (r_mid + {63'b0, r_lp[31]}) : round_shift(r_mid, n_e);
        end else begin
            nres = round_shift(r_mag, 5'(r_k >> 1));
        end
    end

    assign wb_we    = i_cmd.wb_wr;
    assign wb_sat   = saturate(r_neg, nres, VB);
    assign wb_wdata = wb_sat[VB-1:0];
    assign wb_re    = i_cmd.rd_item || (i_cmd.src_rd && (r_r != '0));
    assign wb_raddr = i_cmd.rd_item ? AW'(r_idx) : src_addr;
    assign wb_ext   = {{(GW-VB){wb_rdata[VB-1]}}, wb_rdata};
    assign rd_sat   = saturate(wb_ext[GW-1], wb_ext[GW-1] ? (64'd0 - wb_ext) : wb_ext, VAL_W);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_out_index <= r_idx;
            o_out_value <= r_rd_ok ? rd_sat[VAL_W-1:0] : '0;
        end
    end

    rbh_ram #(.WIDTH(POS_W + 1), .DEPTH(TD)) u_perm (
        .i_clk(i_clk), .i_we(perm_we), .i_waddr(perm_waddr),
        .i_wdata({r_sgn, r_pos}), .i_re(i_cmd.perm_rd), .i_raddr(perm_raddr),
        .o_rdata(perm_rdata)
    );

    rbh_ram #(.WIDTH(VB), .DEPTH(MAX_DIM)) u_vstore (
        .i_clk(i_clk), .i_we(vs_we), .i_waddr(AW'(r_idx)), .i_wdata(vs_wdata),
        .i_re(i_cmd.src_rd && (r_r == '0)), .i_raddr(src_addr), .o_rdata(vs_rdata)
    );

    rbh_ram #(.WIDTH(VB), .DEPTH(MAX_DIM)) u_work (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(r_i), .i_wdata(wb_wdata),
        .i_re(wb_re), .i_raddr(wb_raddr), .o_rdata(wb_rdata)
    );

    rbh_ram #(.WIDTH(GW), .DEPTH(MAX_DIM)) u_gather (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_re(g_re), .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    `RBH_ASSERT(a_lat_after_rd, i_clk, i_rst_n, i_cmd.lat_a |-> $past(i_cmd.g_rd_a), "first operand latched without its read")
endmodule

`default_nettype wire

/* hdl/randomized_block_hadamard_rotation.sv */
// a table write is decoded and written; a data item is scaled and stored; a read item is read
// and loaded into the result register once it is free; a last data item with a nonzero length
// then runs ROUNDS rounds of gather (perm, source, write), butterfly stages (read a, b, sum,
// diff) and normalise; one item in flight, the next is taken once the current one is finished
// reset (synchronous, active low) idles the sequencer, empties the result register and
// sets vector_length to 1024; buffers and tables are left as they are
`default_nettype none

module randomized_block_hadamard_rotation import rbh_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ROUNDS     = ROUNDS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    rbh_item_if.sink                i_in,
    rbh_result_if.source            o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);
    logic [LEN_W-1:0] r_len;
    logic             w_sel_len;
    t_cmd             cmd;
    t_status          st;

    assign pready    = 1'b1;
    assign w_sel_len = (paddr[PADDR_W-1:2] == REG_VECTOR_LENGTH);
    assign prdata    = w_sel_len ? PDATA_W'(r_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_len) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    rbh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_st(st), .o_cmd(cmd)
    );

    rbh_datapath #(
        .MAX_DIM(MAX_DIM), .ROUNDS(ROUNDS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_st(st), .i_len(r_len),
        .i_operation(i_in.operation), .i_round(i_in.round), .i_index(i_in.index),
        .i_source_position(i_in.source_position), .i_sign_negative(i_in.sign_negative),
        .i_value(i_in.value), .i_scale(i_in.scale), .i_last(i_in.last),
        .i_out_ready(o_out.ready), .o_out_valid(o_out.valid),
        .o_out_index(o_out.out_index), .o_out_value(o_out.out_value)
    );
endmodule

`default_nettype wire
